// ===== rtl/core/tfn_pkg.sv =====
// Shared widths, the sideband record and a helper for the triangle face normal pipeline.
package tfn_pkg;

   localparam int COORD_W = 16;
   localparam int DIFF_W  = 17;
   localparam int PROD_W  = 34;
   localparam int CROSS_W = 35;
   localparam int ABS_W   = 34;
   localparam int LEN_W   = 6;
   localparam int MAG_W   = 30;
   localparam int SQ_W    = 60;
   localparam int SUM_W   = 62;
   localparam int RAD_W   = 64;
   localparam int ROOT_W  = 31;
   localparam int ROOT_STEPS = 32;

   // Per-triangle values that ride alongside the root and the divider.
   typedef struct packed {
      logic [2:0][MAG_W-1:0] mag;
      logic [2:0]            neg;
      logic                  deg;
   } side_type;

   // Bit length of a cross product magnitude.
   function automatic logic [LEN_W-1:0] bit_len(input logic [ABS_W-1:0] v);
      logic [LEN_W-1:0] n;
      n = '0;
      for (int i = 0; i < ABS_W; i++) begin
         if (v[i]) begin
            n = LEN_W'(i + 1);
         end
      end
      return n;
   endfunction

endpackage

// ===== rtl/core/tfn_front.sv =====
// Edge vectors, cross product, block normalization and sum of squares.
module tfn_front (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       in_valid,
   output logic                                       in_ready,
   input  logic [2:0][tfn_pkg::COORD_W-1:0]           vert_a,
   input  logic [2:0][tfn_pkg::COORD_W-1:0]           vert_b,
   input  logic [2:0][tfn_pkg::COORD_W-1:0]           vert_c,
   output logic                                       out_valid,
   input  logic                                       out_ready,
   output tfn_pkg::side_type                          out_side,
   output logic [tfn_pkg::SUM_W-1:0]                  out_sum
);

   localparam int NST = 8;

   logic [NST-1:0] vld_ff;
   logic [NST-1:0] vld_src;
   logic [NST-1:0] en;

   logic signed [tfn_pkg::DIFF_W-1:0]  v1_in [3], v2_in [3], v1_ff [3], v2_ff [3];
   logic signed [tfn_pkg::PROD_W-1:0]  pr_in [6], pr_ff [6];
   logic signed [tfn_pkg::CROSS_W-1:0] cr_in [3], cr_ff [3];
   logic [tfn_pkg::ABS_W-1:0]          abs_in [3], abs_ff [3], abs4_ff [3];
   logic [2:0]                         neg3_in, neg3_ff, neg4_ff, neg5_ff, neg6_ff, neg7_ff;
   logic [tfn_pkg::ABS_W-1:0]          max_abs;
   logic [tfn_pkg::LEN_W-1:0]          len_in, len_ff;
   logic                               deg4_in, deg4_ff, deg5_ff, deg6_ff, deg7_ff;
   logic [tfn_pkg::MAG_W-1:0]          u_in [3], u_ff [3], u6_ff [3], u7_ff [3];
   logic [tfn_pkg::SQ_W-1:0]           sq_in [3], sq_ff [3];
   logic [tfn_pkg::SUM_W-1:0]          sum_in, sum_ff;

   // Ready chain: a stage moves when it is empty or the next one moves.
   always_comb begin
      en[NST-1] = !vld_ff[NST-1] || out_ready;
      for (int k = NST - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign vld_src  = {vld_ff[NST-2:0], in_valid};
   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NST; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_src[k];
            end
         end
      end
   end

   // Stage 0: edge vectors a - b and b - c.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         v1_in[i] = $signed({vert_a[i][tfn_pkg::COORD_W-1], vert_a[i]})
                  - $signed({vert_b[i][tfn_pkg::COORD_W-1], vert_b[i]});
         v2_in[i] = $signed({vert_b[i][tfn_pkg::COORD_W-1], vert_b[i]})
                  - $signed({vert_c[i][tfn_pkg::COORD_W-1], vert_c[i]});
      end
   end

   // Stage 1: the six partial products of the cross product.
   always_comb begin
      pr_in[0] = v1_ff[1] * v2_ff[2];
      pr_in[1] = v1_ff[2] * v2_ff[1];
      pr_in[2] = v1_ff[2] * v2_ff[0];
      pr_in[3] = v1_ff[0] * v2_ff[2];
      pr_in[4] = v1_ff[0] * v2_ff[1];
      pr_in[5] = v1_ff[1] * v2_ff[0];
   end

   // Stage 2: cross product components; stage 3: sign and magnitude.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cr_in[i]   = tfn_pkg::CROSS_W'(pr_ff[2*i]) - tfn_pkg::CROSS_W'(pr_ff[2*i+1]);
         neg3_in[i] = cr_ff[i][tfn_pkg::CROSS_W-1];
         abs_in[i]  = neg3_in[i] ? tfn_pkg::ABS_W'(-cr_ff[i]) : tfn_pkg::ABS_W'(cr_ff[i]);
      end
   end

   // Stage 4: largest magnitude and its bit length.
   always_comb begin
      max_abs = abs_ff[0];
      if (abs_ff[1] > max_abs) begin
         max_abs = abs_ff[1];
      end
      if (abs_ff[2] > max_abs) begin
         max_abs = abs_ff[2];
      end
      len_in  = tfn_pkg::bit_len(max_abs);
      deg4_in = (max_abs == '0);
   end

   // Stage 5: shift every magnitude so that the largest has exactly 30 bits.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (len_ff < tfn_pkg::LEN_W'(tfn_pkg::MAG_W)) begin
            u_in[i] = tfn_pkg::MAG_W'(abs4_ff[i] << (tfn_pkg::LEN_W'(tfn_pkg::MAG_W) - len_ff));
         end else begin
            u_in[i] = tfn_pkg::MAG_W'(abs4_ff[i] >> (len_ff - tfn_pkg::LEN_W'(tfn_pkg::MAG_W)));
         end
      end
   end

   // Stage 6: squares; stage 7: their sum.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = u_ff[i] * u_ff[i];
      end
      sum_in = tfn_pkg::SUM_W'(sq_ff[0]) + tfn_pkg::SUM_W'(sq_ff[1])
             + tfn_pkg::SUM_W'(sq_ff[2]);
   end

   // Pipeline data registers.
   always_ff @(posedge clock) begin
      if (en[0]) begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
      if (en[1]) begin
         pr_ff <= pr_in;
      end
      if (en[2]) begin
         cr_ff <= cr_in;
      end
      if (en[3]) begin
         abs_ff  <= abs_in;
         neg3_ff <= neg3_in;
      end
      if (en[4]) begin
         abs4_ff <= abs_ff;
         len_ff  <= len_in;
         deg4_ff <= deg4_in;
         neg4_ff <= neg3_ff;
      end
      if (en[5]) begin
         u_ff    <= u_in;
         deg5_ff <= deg4_ff;
         neg5_ff <= neg4_ff;
      end
      if (en[6]) begin
         sq_ff   <= sq_in;
         u6_ff   <= u_ff;
         deg6_ff <= deg5_ff;
         neg6_ff <= neg5_ff;
      end
      if (en[7]) begin
         sum_ff  <= sum_in;
         u7_ff   <= u6_ff;
         deg7_ff <= deg6_ff;
         neg7_ff <= neg6_ff;
      end
   end

   assign out_valid = vld_ff[NST-1];
   assign out_sum   = sum_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         out_side.mag[i] = u7_ff[i];
      end
      out_side.neg = neg7_ff;
      out_side.deg = deg7_ff;
   end

endmodule

// ===== rtl/core/tfn_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module tfn_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [tfn_pkg::SUM_W-1:0]     in_sum,
   input  tfn_pkg::side_type             in_side,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [tfn_pkg::ROOT_W-1:0]    out_root,
   output tfn_pkg::side_type             out_side
);

   localparam int NST = tfn_pkg::ROOT_STEPS;

   logic [NST-1:0] vld_ff;
   logic [NST-1:0] vld_src;
   logic [NST-1:0] en;

   logic [tfn_pkg::RAD_W-1:0] rem_ff [NST];
   logic [tfn_pkg::RAD_W-1:0] res_ff [NST];
   tfn_pkg::side_type         side_ff [NST];

   // Ready chain through the root stages.
   always_comb begin
      en[NST-1] = !vld_ff[NST-1] || out_ready;
      for (int k = NST - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign vld_src  = {vld_ff[NST-2:0], in_valid};
   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NST; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_src[k];
            end
         end
      end
   end

   // Each stage tries one bit of the root against the running remainder.
   for (genvar g = 0; g < NST; g++) begin : g_step
      localparam logic [tfn_pkg::RAD_W-1:0] BIT_VAL =
         tfn_pkg::RAD_W'(1) << (2 * (NST - 1 - g));
      logic [tfn_pkg::RAD_W-1:0] rem_src, res_src, trial, rem_in, res_in;
      tfn_pkg::side_type         side_src;

      if (g == 0) begin : g_first
         assign rem_src  = tfn_pkg::RAD_W'(in_sum);
         assign res_src  = '0;
         assign side_src = in_side;
      end else begin : g_next
         assign rem_src  = rem_ff[g-1];
         assign res_src  = res_ff[g-1];
         assign side_src = side_ff[g-1];
      end

      always_comb begin
         trial = res_src + BIT_VAL;
         if (rem_src >= trial) begin
            rem_in = rem_src - trial;
            res_in = (res_src >> 1) + BIT_VAL;
         end else begin
            rem_in = rem_src;
            res_in = res_src >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en[g]) begin
            rem_ff[g]  <= rem_in;
            res_ff[g]  <= res_in;
            side_ff[g] <= side_src;
         end
      end
   end

   assign out_valid = vld_ff[NST-1];
   assign out_root  = res_ff[NST-1][tfn_pkg::ROOT_W-1:0];
   assign out_side  = side_ff[NST-1];

endmodule

// ===== rtl/core/tfn_div.sv =====
// Pipelined restoring divider: three rounded quotients u * 2^F / r, one bit per stage.
module tfn_div #(
   parameter int FRAC_BITS = 14
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [tfn_pkg::ROOT_W-1:0]    in_root,
   input  tfn_pkg::side_type             in_side,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [2:0][FRAC_BITS:0]       out_quot,
   output logic [2:0]                    out_neg,
   output logic                          out_deg
);

   localparam int QW  = FRAC_BITS + 1;
   localparam int NW  = tfn_pkg::MAG_W + FRAC_BITS + 2;
   localparam int DW  = tfn_pkg::ROOT_W + 1;
   localparam int NST = QW + 1;

   logic [NST-1:0] vld_ff;
   logic [NST-1:0] vld_src;
   logic [NST-1:0] en;

   logic [2:0][NW-1:0] num_ff  [NST];
   logic [2:0][QW-1:0] quot_ff [NST];
   logic [DW-1:0]      den_ff  [NST];
   logic [2:0]         neg_ff  [NST];
   logic               deg_ff  [NST];

   // Ready chain through the divider stages.
   always_comb begin
      en[NST-1] = !vld_ff[NST-1] || out_ready;
      for (int k = NST - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign vld_src  = {vld_ff[NST-2:0], in_valid};
   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NST; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_src[k];
            end
         end
      end
   end

   // Load stage: dividend u * 2^(F+1) + r and divisor 2r.
   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int i = 0; i < 3; i++) begin
            num_ff[0][i] <= {1'b0, in_side.mag[i], {(FRAC_BITS + 1){1'b0}}} + NW'(in_root);
         end
         quot_ff[0] <= '0;
         den_ff[0]  <= {in_root, 1'b0};
         neg_ff[0]  <= in_side.neg;
         deg_ff[0]  <= in_side.deg;
      end
   end

   // Quotient stages, most significant bit first.
   for (genvar g = 1; g < NST; g++) begin : g_step
      localparam int QB = NST - 1 - g;
      logic [2:0][NW-1:0] num_in;
      logic [2:0][QW-1:0] quot_in;
      logic [NW-1:0]      trial;

      always_comb begin
         trial = NW'(den_ff[g-1]) << QB;
         for (int i = 0; i < 3; i++) begin
            num_in[i]  = num_ff[g-1][i];
            quot_in[i] = quot_ff[g-1][i];
            if (num_ff[g-1][i] >= trial) begin
               num_in[i]      = num_ff[g-1][i] - trial;
               quot_in[i][QB] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en[g]) begin
            num_ff[g]  <= num_in;
            quot_ff[g] <= quot_in;
            den_ff[g]  <= den_ff[g-1];
            neg_ff[g]  <= neg_ff[g-1];
            deg_ff[g]  <= deg_ff[g-1];
         end
      end
   end

   assign out_valid = vld_ff[NST-1];
   assign out_quot  = quot_ff[NST-1];
   assign out_neg   = neg_ff[NST-1];
   assign out_deg   = deg_ff[NST-1];

endmodule

// ===== rtl/core/triangle_face_normal.sv =====
// Top level of the triangle face normal pipeline.
//
// Usage: one triangle word enters on the req_ stream (nine signed Q2.14
// coordinates), one normal word leaves on the rsp_ stream for each triangle,
// in order. The result carries three signed components with
// COORD_FRAC_BITS fractional bits and, in rsp_tuser, a degenerate flag that
// is set with a zero normal when the three vertices are collinear.
// Pipeline: the cross product and normalization stages, 32 square root
// stages, COORD_FRAC_BITS + 2 divider stages and one output register lie
// between accept and rsp_tvalid.
// Throughput: one triangle per cycle while rsp_tready is high; the square
// root and the divider are unrolled into one bit per stage so every stage can take a new word each cycle.
// Reset clears every stage valid bit; data registers are not cleared.
// When the receiver holds rsp_tready low the output word waits, and stages
// behind it keep filling their empty slots; req_tready falls only once every
// stage holds a word.
module triangle_face_normal #(
   parameter int COORD_FRAC_BITS = 14
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (16 bits each)
   input  logic [143:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // normal_x, normal_y, normal_z (16 bits each)
   output logic [47:0]   rsp_tdata,
   // degenerate
   output logic [0:0]    rsp_tuser
);

   localparam int QW = COORD_FRAC_BITS + 1;
   localparam logic [31:0] LIM = (COORD_FRAC_BITS >= 15) ? 32'd32767
                                                        : (32'd1 << COORD_FRAC_BITS);

   logic [2:0][tfn_pkg::COORD_W-1:0] vert_a, vert_b, vert_c;

   logic                           fr_valid, fr_ready;
   tfn_pkg::side_type              fr_side;
   logic [tfn_pkg::SUM_W-1:0]      fr_sum;

   logic                           sq_valid, sq_ready;
   logic [tfn_pkg::ROOT_W-1:0]     sq_root;
   tfn_pkg::side_type              sq_side;

   logic                           dv_valid, dv_ready;
   logic [2:0][QW-1:0]             dv_quot;
   logic [2:0]                     dv_neg;
   logic                           dv_deg;

   logic                           rsp_vld_ff;
   logic [47:0]                    rsp_data_ff, rsp_data_in;
   logic                           rsp_deg_ff;
   logic [tfn_pkg::COORD_W-1:0]    clip;

   // Unpack the triangle word.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vert_a[i] = req_tdata[16*i +: 16];
         vert_b[i] = req_tdata[48 + 16*i +: 16];
         vert_c[i] = req_tdata[96 + 16*i +: 16];
      end
   end

   tfn_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .vert_a    (vert_a),
      .vert_b    (vert_b),
      .vert_c    (vert_c),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .out_side  (fr_side),
      .out_sum   (fr_sum)
   );

   tfn_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_sum    (fr_sum),
      .in_side   (fr_side),
      .out_valid (sq_valid),
      .out_ready (sq_ready),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   tfn_div #(
      .FRAC_BITS (COORD_FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_ready  (sq_ready),
      .in_root   (sq_root),
      .in_side   (sq_side),
      .out_valid (dv_valid),
      .out_ready (dv_ready),
      .out_quot  (dv_quot),
      .out_neg   (dv_neg),
      .out_deg   (dv_deg)
   );

   // Saturate, apply the sign and zero out degenerate triangles.
   always_comb begin
      rsp_data_in = '0;
      for (int i = 0; i < 3; i++) begin
         if (32'(dv_quot[i]) > LIM) begin
            clip = LIM[15:0];
         end else begin
            clip = 16'(dv_quot[i]);
         end
         if (!dv_deg) begin
            rsp_data_in[16*i +: 16] = dv_neg[i] ? (16'd0 - clip) : clip;
         end
      end
   end

   assign dv_ready = !rsp_vld_ff || rsp_tready;

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (dv_ready) begin
         rsp_vld_ff <= dv_valid;
      end
      if (dv_ready) begin
         rsp_data_ff <= rsp_data_in;
         rsp_deg_ff  <= dv_deg;
      end
   end

   assign rsp_tvalid   = rsp_vld_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_deg_ff;

endmodule

// ===== rtl/core/tfn_checker.sv =====
// Port-level checks for the triangle face normal block, bound to the top level.
module tfn_checker (
   input logic          clock,
   input logic          reset,
   input logic          req_tready,
   input logic          rsp_tvalid,
   input logic          rsp_tready,
   input logic [47:0]   rsp_tdata,
   input logic [0:0]    rsp_tuser
);

   // No word is offered right after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   // A stalled output word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled output word changed");

   // A degenerate triangle gives a zero normal.
   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 48'd0)
      else $error("degenerate word with nonzero normal");

   // Input back-pressure only comes from a stalled output.
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("req_tready low without output stall");

endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== verif/triangle_face_normal_tb.sv =====
// Self-checking testbench for the triangle face normal pipeline.
`timescale 1ns / 1ps

module triangle_face_normal_tb;

   localparam int FRAC = 14;
   localparam int LATENCY = FRAC + 43;
   localparam longint CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } vec_type;

   typedef struct {
      logic [15:0] nx;
      logic [15:0] ny;
      logic [15:0] nz;
      logic        deg;
   } normal_type;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [143:0]  req_tdata;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [47:0]   rsp_tdata;
   logic [0:0]    rsp_tuser;

   logic [143:0]  pending_tris[$];
   normal_type    expected_normals[$];
   int            error_count = 0;
   longint        cycle_count = 0;

   triangle_face_normal #(.COORD_FRAC_BITS(FRAC)) uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Integer square root, floor.
   function automatic longint unsigned int_sqrt(input longint unsigned s);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv >>= 2;
      while (bitv != 0) begin
         if (s >= res + bitv) begin
            s -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // Unit normal of one triangle word.
   function automatic normal_type face_normal(input logic [143:0] w);
      longint signed c[9];
      longint signed e1[3], e2[3], cr[3];
      longint unsigned mag[3], maxm, s, r, q, lim;
      bit neg[3];
      int len;
      normal_type res;
      for (int i = 0; i < 9; i++) c[i] = longint'($signed(w[16*i +: 16]));
      for (int i = 0; i < 3; i++) begin
         e1[i] = c[i] - c[3+i];
         e2[i] = c[3+i] - c[6+i];
      end
      cr[0] = e1[1]*e2[2] - e1[2]*e2[1];
      cr[1] = e1[2]*e2[0] - e1[0]*e2[2];
      cr[2] = e1[0]*e2[1] - e1[1]*e2[0];
      maxm = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = cr[i] < 0;
         mag[i] = neg[i] ? -cr[i] : cr[i];
         if (mag[i] > maxm) maxm = mag[i];
      end
      res = '{16'd0, 16'd0, 16'd0, 1'b1};
      if (maxm == 0) return res;
      len = 0;
      for (int i = 0; i < 64; i++) if (maxm[i]) len = i + 1;
      s = 0;
      for (int i = 0; i < 3; i++) begin
         if (len < 30) mag[i] <<= (30 - len);
         else if (len > 30) mag[i] >>= (len - 30);
         s += mag[i] * mag[i];
      end
      r = int_sqrt(s);
      lim = 64'd1 << FRAC;
      if (lim > 32767) lim = 32767;
      for (int i = 0; i < 3; i++) begin
         q = ((mag[i] << (FRAC + 1)) + r) / (2 * r);
         if (q > lim) q = lim;
         mag[i] = neg[i] ? -q : q;
      end
      res.nx = mag[0][15:0];
      res.ny = mag[1][15:0];
      res.nz = mag[2][15:0];
      res.deg = 1'b0;
      return res;
   endfunction

   function automatic logic [143:0] pack_tri(input vec_type a, input vec_type b,
                                            input vec_type c);
      return {c.z, c.y, c.x, b.z, b.y, b.x, a.z, a.y, a.x};
   endfunction

   function automatic logic [15:0] rand_coord(input int mode);
      case (mode)
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($urandom_range(0, 64)) - 16'd32;
         default: return 16'($urandom);
      endcase
   endfunction

   // Appends one triangle word to the pending queue.
   function automatic void add_tri(input logic [143:0] w);
      pending_tris.insert(pending_tris.size(), w);
   endfunction

   // Sampled handshake of the request side at the last rising edge.
   logic req_tready_seen;

   // Driver: presents pending triangles with random gaps.
   int send_gap;
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         send_gap = $urandom_range(0, 10);
      end else if (!req_tvalid || req_tready_seen) begin
         if (send_gap > 0 || pending_tris.size() == 0) begin
            req_tvalid <= 1'b0;
            if (send_gap > 0) send_gap--;
         end else begin
            req_tdata <= pending_tris.pop_front();
            req_tvalid <= 1'b1;
            send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            if ($urandom_range(0, 1) == 0) send_gap = 0;
         end
      end
   end

   always @(posedge clock) begin
      req_tready_seen <= req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready)
         expected_normals.insert(expected_normals.size(), face_normal(req_tdata));
   end

   // Receiver back-pressure.
   int stall_left;
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(0, 10);
      end
   end

   // Monitor: compares each accepted normal word with the oldest prediction.
   always @(posedge clock) begin
      normal_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_normals.size() == 0) begin
            $error("unexpected normal word %h", rsp_tdata);
            error_count++;
         end else begin
            want = expected_normals.pop_front();
            if (rsp_tdata[15:0] !== want.nx) begin
               $error("normal_x expected %h actual %h", want.nx, rsp_tdata[15:0]);
               error_count++;
            end
            if (rsp_tdata[31:16] !== want.ny) begin
               $error("normal_y expected %h actual %h", want.ny, rsp_tdata[31:16]);
               error_count++;
            end
            if (rsp_tdata[47:32] !== want.nz) begin
               $error("normal_z expected %h actual %h", want.nz, rsp_tdata[47:32]);
               error_count++;
            end
            if (rsp_tuser[0] !== want.deg) begin
               $error("degenerate expected %b actual %b", want.deg, rsp_tuser[0]);
               error_count++;
            end
         end
      end
   end

   // Timeout guard.
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Stimulus and end of run.
   initial begin
      vec_type a, b, c;
      int mode;
      reset = 1'b1;
      // Directed: degenerate cases, extremes, saturation-prone triangles.
      add_tri('0);
      add_tri(pack_tri('{16'h1000, 16'h1000, 16'h1000},
                       '{16'h1000, 16'h1000, 16'h1000},
                       '{16'h1000, 16'h1000, 16'h1000}));
      add_tri(pack_tri('{16'd0, 16'd0, 16'd0}, '{16'd1, 16'd1, 16'd1},
                       '{16'd2, 16'd2, 16'd2}));
      add_tri(pack_tri('{16'd1, 16'd0, 16'd0}, '{16'd0, 16'd0, 16'd0},
                       '{16'd0, 16'hFFFF, 16'd0}));
      add_tri(pack_tri('{16'h4000, 16'd0, 16'd0}, '{16'd0, 16'd0, 16'd0},
                       '{16'd0, 16'h4000, 16'd0}));
      add_tri(pack_tri('{16'h7FFF, 16'h8000, 16'h7FFF},
                       '{16'h8000, 16'h7FFF, 16'h8000},
                       '{16'h7FFF, 16'h7FFF, 16'h8000}));
      add_tri(pack_tri('{16'h8000, 16'h8000, 16'h8000},
                       '{16'h7FFF, 16'h8000, 16'h8000},
                       '{16'h8000, 16'h7FFF, 16'h8000}));
      add_tri(pack_tri('{16'h7FFF, 16'h7FFF, 16'h7FFF},
                       '{16'h8000, 16'h7FFF, 16'h7FFF},
                       '{16'h7FFF, 16'h8000, 16'h7FFF}));
      add_tri(pack_tri('{16'd3, 16'd1, 16'd2}, '{16'd3, 16'd1, 16'd3},
                       '{16'd4, 16'd1, 16'd3}));
      add_tri({144{1'b1}});
      add_tri({72{2'b10}});
      add_tri({72{2'b01}});
      // Random triangles: mostly full range, some tiny or collinear.
      for (int n = 0; n < 900; n++) begin
         mode = $urandom_range(0, 9);
         if (mode < 6) begin
            add_tri({$urandom, $urandom, $urandom, $urandom, 16'($urandom)});
         end else if (mode < 8) begin
            add_tri(pack_tri(
               '{rand_coord($urandom_range(0, 3)), rand_coord($urandom_range(0, 3)),
                 rand_coord($urandom_range(0, 3))},
               '{rand_coord($urandom_range(0, 3)), rand_coord($urandom_range(0, 3)),
                 rand_coord($urandom_range(0, 3))},
               '{rand_coord($urandom_range(0, 3)), rand_coord($urandom_range(0, 3)),
                 rand_coord($urandom_range(0, 3))}));
         end else begin
            // Collinear: c = b + (b - a); the coordinates are small, so no wrap and always degenerate.
            a = '{rand_coord(2), rand_coord(2), rand_coord(2)};
            b = '{rand_coord(2), rand_coord(2), rand_coord(2)};
            c.x = 16'(2 * b.x - a.x);
            c.y = 16'(2 * b.y - a.y);
            c.z = 16'(2 * b.z - a.z);
            add_tri(pack_tri(a, b, c));
         end
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      while (pending_tris.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_normals.size() != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      if (error_count == 0 && expected_normals.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
